// ===== src/chtlp_pkg.sv =====
package chtlp_pkg;

    localparam int KEY_W       = 64;
    localparam int HALF_W      = 32;
    localparam int MODE_W      = 2;
    localparam int CFG_W       = 4;
    localparam int OUT_COUNT_W = 32;

    localparam logic [KEY_W-1:0] HASH_MUL       = 64'd12345678911234567891;
    localparam logic [CFG_W-1:0] TABLE_BITS_RST = 4'd10;

    // Operation codes carried in the input tuser.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Operand pairs for the shared 32 x 32 multiplier.
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_LH = 2'd1;
    localparam logic [1:0] MUL_HL = 2'd2;

    // Hash accumulator operations.
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // Result kinds.
    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_OVF  = 2'd1;
    localparam logic [1:0] RES_INS  = 2'd2;
    localparam logic [1:0] RES_FIND = 2'd3;

    typedef struct packed {
        logic       load_key;
        logic [1:0] mul_sel;
        logic [1:0] acc_op;
        logic       idx_load;
        logic       idx_inc;
        logic       rd_en;
        logic       wr_upd;
        logic       clr_wr;
        logic       clr_idx_rst;
        logic       clr_idx_inc;
        logic       res_set;
        logic [1:0] res_kind;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit;
        logic hit;
        logic clr_last;
    } t_dp_sts;

endpackage

// ===== src/chtlp_dp.sv =====
module chtlp_dp #(
    parameter int MAX_TABLE_BITS = 10,
    parameter int OVERFLOW_SLOTS = 105,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chtlp_pkg::t_dp_cmd                  i_cmd,
    output chtlp_pkg::t_dp_sts                  o_sts,
    input  logic [chtlp_pkg::KEY_W-1:0]         i_key,
    input  logic                                i_cfg_we,
    input  logic [chtlp_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic [chtlp_pkg::OUT_COUNT_W-1:0]   o_count,
    output logic                                o_ovf
);
    import chtlp_pkg::*;

    localparam int TOTAL_SLOTS = (1 << MAX_TABLE_BITS) + OVERFLOW_SLOTS;
    localparam int IDX_W       = $clog2(TOTAL_SLOTS);
    localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
    localparam int EB_W        = $clog2(MAX_TABLE_BITS + 1);
    localparam int MEM_W       = KEY_W + COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [CFG_W-1:0]        r_table_bits;
    logic [CNT_W-1:0]        r_limit;
    logic [5:0]              r_shift;
    logic [KEY_W-1:0]        r_key;
    logic [2*HALF_W-1:0]     r_prod;
    logic [HALF_W-1:0]       r_hi;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_clr_idx;
    logic [MEM_W-1:0]        r_rd_data;
    logic [OUT_COUNT_W-1:0]  r_res_count;
    logic                    r_res_ovf;
    logic [OUT_COUNT_W-1:0]  r_out_count;
    logic                    r_out_ovf;

    logic [MEM_W-1:0] mem [TOTAL_SLOTS];

    logic [EB_W-1:0]         eff_bits;
    logic [HALF_W-1:0]       mul_a;
    logic [HALF_W-1:0]       mul_b;
    logic [KEY_W-1:0]        rd_key;
    logic [COUNT_WIDTH-1:0]  rd_cnt;
    logic [COUNT_WIDTH-1:0]  ins_cnt;
    logic [COUNT_WIDTH-1:0]  sel_cnt;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] sel_ext;

    // Out-of-range register values are clamped into the supported table sizes.
    always_comb begin
        if (int'(r_table_bits) > MAX_TABLE_BITS) begin
            eff_bits = EB_W'(MAX_TABLE_BITS);
        end else if (r_table_bits == '0) begin
            eff_bits = EB_W'(1);
        end else begin
            eff_bits = EB_W'(r_table_bits);
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_LL: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = HASH_MUL[HALF_W-1:0];
            end
            MUL_LH: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = HASH_MUL[KEY_W-1:HALF_W];
            end
            MUL_HL: begin
                mul_a = r_key[KEY_W-1:HALF_W];
                mul_b = HASH_MUL[HALF_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rd_key = r_rd_data[MEM_W-1:COUNT_WIDTH];
    assign rd_cnt = r_rd_data[COUNT_WIDTH-1:0];

    always_comb begin
        if (rd_cnt == '0) begin
            ins_cnt = COUNT_WIDTH'(1);
        end else if (rd_cnt != COUNT_MAX) begin
            ins_cnt = rd_cnt + COUNT_WIDTH'(1);
        end else begin
            ins_cnt = rd_cnt;
        end
    end

    assign sel_cnt = (i_cmd.res_kind == RES_INS) ? ins_cnt : rd_cnt;
    assign sel_ext = {{OUT_COUNT_W{1'b0}}, sel_cnt};

    assign o_sts.at_limit = (r_idx >= r_limit);
    assign o_sts.hit      = (rd_cnt == '0) || (rd_key == r_key);
    assign o_sts.clr_last = (r_clr_idx == CNT_W'(TOTAL_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits <= TABLE_BITS_RST;
            r_clr_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_bits <= i_cfg_wdata;
            end
            if (i_cmd.clr_idx_rst) begin
                r_clr_idx <= '0;
            end else if (i_cmd.clr_idx_inc) begin
                r_clr_idx <= r_clr_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= (CNT_W'(1) << eff_bits) + CNT_W'(OVERFLOW_SLOTS);
        r_shift <= 6'(HALF_W) - 6'(eff_bits);

        if (i_cmd.load_key) begin
            r_key <= i_key;
        end

        // The hash needs only the upper word of the product mod 2^64:
        // high(lo*lo) + low(lo*hi) + low(hi*lo).
        r_prod <= mul_a * mul_b;
        case (i_cmd.acc_op)
            ACC_LOAD: r_hi <= r_prod[2*HALF_W-1:HALF_W];
            ACC_ADD:  r_hi <= r_hi + r_prod[HALF_W-1:0];
            default:  r_hi <= r_hi;
        endcase

        if (i_cmd.idx_load) begin
            r_idx <= CNT_W'(r_hi >> r_shift);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end

        if (i_cmd.res_set) begin
            case (i_cmd.res_kind) inside
                RES_INS, RES_FIND: begin
                    r_res_count <= sel_ext[OUT_COUNT_W-1:0];
                    r_res_ovf   <= 1'b0;
                end
                RES_OVF: begin
                    r_res_count <= '0;
                    r_res_ovf   <= 1'b1;
                end
                default: begin
                    r_res_count <= '0;
                    r_res_ovf   <= 1'b0;
                end
            endcase
        end

        if (i_cmd.out_load) begin
            r_out_count <= r_res_count;
            r_out_ovf   <= r_res_ovf;
        end
    end

    // Slot memory: key in the upper bits, count in the lower bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_idx[IDX_W-1:0]] <= '0;
        end else if (i_cmd.wr_upd) begin
            mem[r_idx[IDX_W-1:0]] <= {r_key, ins_cnt};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_count = r_out_count;
    assign o_ovf   = r_out_ovf;

endmodule

// ===== src/chtlp_ctrl.sv =====
module chtlp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [chtlp_pkg::MODE_W-1:0] i_mode,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_we,
    input  chtlp_pkg::t_dp_sts           i_sts,
    output chtlp_pkg::t_dp_cmd           o_cmd
);
    import chtlp_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_H0   = 4'd2;
    localparam logic [3:0] S_H1   = 4'd3;
    localparam logic [3:0] S_H2   = 4'd4;
    localparam logic [3:0] S_H3   = 4'd5;
    localparam logic [3:0] S_HIDX = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ins;
    logic       n_ins;
    logic       r_clr_item;
    logic       n_clr_item;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       s_accept;

    assign o_s_tready = (r_state == S_IDLE) && !i_cfg_we;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_ins       = r_ins;
        n_clr_item  = r_clr_item;
        n_out_valid = r_out_valid && !i_m_tready;

        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.clr_idx_rst = 1'b1;
                    if (r_clr_item) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RES_ZERO;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.clr_idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    o_cmd.load_key = 1'b1;
                    unique case (i_mode) inside
                        MODE_INSERT, MODE_FIND: begin
                            n_ins   = (i_mode == MODE_INSERT);
                            n_state = S_H0;
                        end
                        MODE_CLEAR: begin
                            n_clr_item = 1'b1;
                            n_state    = S_CLR;
                        end
                        default: begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = RES_ZERO;
                            n_state        = S_DONE;
                        end
                    endcase
                end
            end
            S_H0: begin
                o_cmd.mul_sel = MUL_LL;
                n_state       = S_H1;
            end
            S_H1: begin
                o_cmd.mul_sel = MUL_LH;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = S_H2;
            end
            S_H2: begin
                o_cmd.mul_sel = MUL_HL;
                o_cmd.acc_op  = ACC_ADD;
                n_state       = S_H3;
            end
            S_H3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_HIDX;
            end
            S_HIDX: begin
                o_cmd.idx_load = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                if (i_sts.at_limit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_OVF;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.wr_upd   = r_ins;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = r_ins ? RES_INS : RES_FIND;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_DONE: begin
                // Hand over to the output register once it is free.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A register write restarts the clearing pass from the first slot.
        if (i_cfg_we) begin
            o_cmd.clr_idx_rst = 1'b1;
            o_cmd.clr_idx_inc = 1'b0;
            o_cmd.clr_wr      = 1'b0;
            n_clr_item        = 1'b0;
            n_state           = S_CLR;
        end else if (r_state == S_CLR && i_sts.clr_last) begin
            n_clr_item = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ins       <= 1'b0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ins       <= n_ins;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/counting_hash_table_linear_probe.sv =====
// Counting hash table with linear probing.
// Input stream: tuser carries the operation (insert, find, clear) and tdata the
// 64-bit key. Output stream: tdata carries the count and tuser the overflow flag.
// Exactly one result transaction follows every input transaction, in order, unless a
// table size register write aborts it. Insert and find hash the key on one shared
// 32 x 32 multiplier, then take one memory read and one compare per probed slot,
// and then load the output register.
// A clear sweeps all (1 << MAX_TABLE_BITS) + OVERFLOW_SLOTS entries (1129 by
// default) of the slot memory one entry a cycle, before its result.
// After reset, and after every write of the table size register, the same sweep
// runs with tready low; register writes are still taken during it.
// Only one transaction is in flight. The result sits in an output register, so
// the next input transaction is accepted while the receiver stalls; the block then
// waits at the end of that item until the output register is free.
module counting_hash_table_linear_probe #(
    parameter int MAX_TABLE_BITS = 10,
    parameter int OVERFLOW_SLOTS = 105,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [chtlp_pkg::KEY_W-1:0]         i_s_axis_tdata,  // key[63:0]
    input  logic [chtlp_pkg::MODE_W-1:0]        i_s_axis_tuser,  // mode[1:0]
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [chtlp_pkg::OUT_COUNT_W-1:0]   o_m_axis_tdata,  // count[31:0]
    output logic [0:0]                          o_m_axis_tuser,  // overflow[0]
    input  logic                                i_cfg_we,
    input  logic [chtlp_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import chtlp_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    out_ovf;

    chtlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    chtlp_dp #(
        .MAX_TABLE_BITS (MAX_TABLE_BITS),
        .OVERFLOW_SLOTS (OVERFLOW_SLOTS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_key       (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_count     (o_m_axis_tdata),
        .o_ovf       (out_ovf)
    );

    assign o_m_axis_tuser = out_ovf;

endmodule

// ===== src/chtlp_chk.sv =====
module chtlp_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [chtlp_pkg::OUT_COUNT_W-1:0]   o_m_axis_tdata,
    input logic [0:0]                          o_m_axis_tuser,
    input logic                                i_cfg_we
);
    import chtlp_pkg::*;

    logic s_accept;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // One transaction at a time: the input closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("input accepted while a transaction is still in flight");

    // A register write starts a clearing pass, so no input can follow at once.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_axis_tready)
        else $error("input ready right after a table size write");

    // An overflowed probe never reports a count.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("overflow result with nonzero count");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind counting_hash_table_linear_probe chtlp_chk u_chtlp_chk (.*);
